// File: rtl/core/mtd_pkg.sv
// Shared constants and types of the multichannel timed debouncer.
`default_nettype none
package mtd_pkg;

  localparam int NUM_BOARDS_DEF   = 4;
  localparam int NUM_CHANNELS_DEF = 64;

  localparam int CH_W           = 6;
  localparam int TIME_W         = 32;
  localparam int DEB_W          = 13;
  localparam int MASK_W         = 64;
  localparam int CNT_W          = 3;
  localparam int READY_W        = 4;
  localparam int PINS_PER_BOARD = 16;
  localparam int BOARD_W        = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_LIMIT = 13'd5000;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 13'd50;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  // Register indexes (byte address is eight times the index).
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] REG_INVERT      = 3'd3;
  localparam logic [2:0] REG_MAPPED      = 3'd4;
  localparam logic [2:0] REG_EXP_COUNT   = 3'd5;
  localparam logic [2:0] REG_BOARD_READY = 3'd6;

  // Per-channel debounce state held in the channel memory.
  typedef struct packed {
    logic              cand;
    logic              stab;
    logic [TIME_W-1:0] since;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// File: rtl/core/multichannel_timed_debouncer.sv
// Multichannel timed debouncer: top level with the channel pipeline and registers.
//
// Usage: each input transaction carries one raw pin sample for one channel and a
// millisecond timestamp. Samples for disabled, unmapped or absent/unready boards
// are dropped without a result. A channel's first sample after reset or after
// any register write seeds its state and is reported; later a level that has
// differed from the stable level for the debounce time flips the stable level
// and is reported. Each sample yields zero or one output transaction.
// An accepted sample is registered into the update stage, its result if any into the
// output register. One sample per cycle is taken unless the output stalls; the channel
// memory is read on acceptance and written back as the sample leaves the update stage,
// and a write-back register forwards the latest entry to a following sample of the same channel.
// When the output is stalled with a result waiting, one more sample is still
// taken into the update stage; the input stalls only when that stage is also
// full. Reset clears the registers to their defaults (debounce time 50 ms)
// and marks every channel as not yet seeded; the memory needs no clearing.
// Registers are written through the APB-style port at 8-byte spacing and
// should be changed only while no samples are in flight.
`default_nettype none
module multichannel_timed_debouncer #(
  parameter int NUM_BOARDS   = mtd_pkg::NUM_BOARDS_DEF,
  parameter int NUM_CHANNELS = mtd_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [mtd_pkg::CH_W-1:0]       in_channel_index,
  input  wire logic                           in_raw_level,
  input  wire logic [mtd_pkg::TIME_W-1:0]     in_now_ms,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [mtd_pkg::CH_W-1:0]       out_report_channel,
  output logic                                out_report_active,

  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mtd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mtd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mtd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  import mtd_pkg::*;

  localparam int CH_AW = $clog2(NUM_CHANNELS);

  // Configuration registers.
  logic               enable_r, enable_nxt;
  logic               active_high_r, active_high_nxt;
  logic [DEB_W-1:0]   debounce_r, debounce_nxt;
  logic [MASK_W-1:0]  invert_r, invert_nxt;
  logic [MASK_W-1:0]  mapped_r, mapped_nxt;
  logic [CNT_W-1:0]   exp_count_r, exp_count_nxt;
  logic [READY_W-1:0] board_ready_r, board_ready_nxt;

  logic [NUM_CHANNELS-1:0] init_r, init_nxt;

  // Update stage.
  logic              s1_valid_r, s1_valid_nxt;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_raw_r;
  logic [TIME_W-1:0] s1_now_r;

  // Write-back forwarding.
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [CH_AW-1:0]  fwd_ch_r;
  entry_t            fwd_data_r;

  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_ch_r;
  logic              out_active_r;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic              cfg_hit;
  logic              accept;
  logic              s1_move;
  logic              proc;
  logic [BOARD_W-1:0] board;
  logic [CH_AW-1:0]  s1_addr;
  logic              active;
  entry_t            rd_entry;
  entry_t            cur;
  entry_t            upd;
  logic              result;
  logic [DEB_W-1:0]  limit;
  logic [TIME_W-1:0] elapsed;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    enable_nxt      = enable_r;
    active_high_nxt = active_high_r;
    debounce_nxt    = debounce_r;
    invert_nxt      = invert_r;
    mapped_nxt      = mapped_r;
    exp_count_nxt   = exp_count_r;
    board_ready_nxt = board_ready_r;
    cfg_hit         = 1'b0;
    if (cfg_wr) begin
      cfg_hit = 1'b1;
      unique case (cfg_idx)
        REG_ENABLE:      enable_nxt      = pwdata[0];
        REG_ACTIVE_HIGH: active_high_nxt = pwdata[0];
        REG_DEBOUNCE:    debounce_nxt    = pwdata[DEB_W-1:0];
        REG_INVERT:      invert_nxt      = pwdata;
        REG_MAPPED:      mapped_nxt      = pwdata;
        REG_EXP_COUNT:   exp_count_nxt   = pwdata[CNT_W-1:0];
        REG_BOARD_READY: board_ready_nxt = pwdata[READY_W-1:0];
        default:         cfg_hit         = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:      prdata = {{(CFG_DATA_W-1){1'b0}}, enable_r};
      REG_ACTIVE_HIGH: prdata = {{(CFG_DATA_W-1){1'b0}}, active_high_r};
      REG_DEBOUNCE:    prdata = {{(CFG_DATA_W-DEB_W){1'b0}}, debounce_r};
      REG_INVERT:      prdata = invert_r;
      REG_MAPPED:      prdata = mapped_r;
      REG_EXP_COUNT:   prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, exp_count_r};
      REG_BOARD_READY: prdata = {{(CFG_DATA_W-READY_W){1'b0}}, board_ready_r};
      default:         prdata = '0;
    endcase
  end

  // The update stage moves on unless it would overwrite a stalled result.
  assign s1_move  = ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & ~s1_move;
  assign accept   = in_valid & ~in_stall;

  mtd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_CHANNELS)
  ) u_chan_ram (
    .clk  (clk),
    .we   (s1_valid_r & s1_move & proc),
    .waddr(s1_addr),
    .wdata(upd),
    .re   (accept),
    .raddr(in_channel_index[CH_AW-1:0]),
    .rdata(rd_entry)
  );

  assign s1_addr = s1_ch_r[CH_AW-1:0];
  assign board   = s1_ch_r[CH_W-1:CH_W-BOARD_W];

  always_comb begin
    proc = enable_r
         & ({1'b0, s1_ch_r} < 7'(NUM_CHANNELS))
         & mapped_r[s1_ch_r]
         & ({1'b0, board} < exp_count_r)
         & (4'(board) < 4'(NUM_BOARDS))
         & board_ready_r[board];
    active = (active_high_r ^ invert_r[s1_ch_r]) ? s1_raw_r : ~s1_raw_r;
    cur    = (fwd_valid_r && fwd_ch_r == s1_addr) ? fwd_data_r : rd_entry;
    limit  = (debounce_r > DEBOUNCE_LIMIT) ? DEBOUNCE_LIMIT : debounce_r;

    upd     = cur;
    result  = 1'b0;
    elapsed = '0;
    if (!init_r[s1_addr]) begin
      upd.cand  = active;
      upd.stab  = active;
      upd.since = s1_now_r;
      result    = 1'b1;
    end else begin
      if (active != cur.cand) begin
        upd.cand  = active;
        upd.since = s1_now_r;
      end
      elapsed = s1_now_r - upd.since;
      if (upd.cand != upd.stab && elapsed >= {{(TIME_W-DEB_W){1'b0}}, limit}) begin
        upd.stab = upd.cand;
        result   = 1'b1;
      end
    end
  end

  always_comb begin
    init_nxt      = init_r;
    s1_valid_nxt  = s1_valid_r;
    fwd_valid_nxt = fwd_valid_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (s1_valid_r && s1_move) begin
      s1_valid_nxt = 1'b0;
      if (proc) begin
        init_nxt[s1_addr] = 1'b1;
        fwd_valid_nxt     = 1'b1;
        if (result) begin
          out_valid_nxt = 1'b1;
        end
      end
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
    if (cfg_hit) begin
      init_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      active_high_r <= 1'b0;
      debounce_r    <= DEBOUNCE_RESET;
      invert_r      <= '0;
      mapped_r      <= '0;
      exp_count_r   <= '0;
      board_ready_r <= '0;
      init_r        <= '0;
      s1_valid_r    <= 1'b0;
      fwd_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      enable_r      <= enable_nxt;
      active_high_r <= active_high_nxt;
      debounce_r    <= debounce_nxt;
      invert_r      <= invert_nxt;
      mapped_r      <= mapped_nxt;
      exp_count_r   <= exp_count_nxt;
      board_ready_r <= board_ready_nxt;
      init_r        <= init_nxt;
      s1_valid_r    <= s1_valid_nxt;
      fwd_valid_r   <= fwd_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r  <= in_channel_index;
      s1_raw_r <= in_raw_level;
      s1_now_r <= in_now_ms;
    end
    if (s1_valid_r && s1_move && proc) begin
      fwd_ch_r   <= s1_addr;
      fwd_data_r <= upd;
      if (result) begin
        out_ch_r     <= s1_ch_r;
        out_active_r <= upd.stab;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_channel = out_ch_r;
  assign out_report_active  = out_active_r;

endmodule
`default_nettype wire

// File: rtl/core/mtd_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none
module mtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
